// ===== hdl/lavm_pkg.sv =====
// lavm_pkg: shared types, register codes and rounding helpers for the look-at view matrix
// depends on nothing; imported by lavm_norm, look_at_view_matrix and look_at_view_matrix_test
package lavm_pkg;

   // default fraction bits of every fixed-point value
   localparam int unsigned FRAC_BITS_DEF = 16;

   // fixed-point vector element types
   typedef logic signed [31:0] fix_type;
   typedef logic signed [63:0] wide_type;
   typedef logic signed [33:0] vec_type;
   typedef logic signed [67:0] acc_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_UP_X = 2'd0,
      CSR_UP_Y = 2'd1,
      CSR_UP_Z = 2'd2,
      CSR_ZOOM = 2'd3
   } csr_idx_type;

   // matrix row codes
   typedef enum logic [1:0] {
      ROW_SIDE  = 2'd0,
      ROW_UP    = 2'd1,
      ROW_BACK  = 2'd2,
      ROW_HOMOG = 2'd3
   } rowsel_type;

   // register reset values
   localparam fix_type     UP_X_RST = 32'sd0;
   localparam fix_type     UP_Y_RST = 32'sd0;
   localparam fix_type     UP_Z_RST = 32'sd65536;
   localparam logic [30:0] ZOOM_RST = 31'd65536;

   // request word: camera position and target
   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] aim_x;
      logic signed [31:0] aim_y;
      logic signed [31:0] aim_z;
   } req_type;

   // response word: one matrix row
   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col_zero;
      logic signed [31:0] col_one;
      logic signed [31:0] col_two;
      logic signed [31:0] col_three;
      logic               last_row;
   } rsp_type;

   // cycles through the normalize unit
   function automatic int unsigned norm_lat(int unsigned f);
      return 27 + ((f + 2) >> 1);
   endfunction

   // shift right by s with rounding of the magnitude, ties away from zero
   function automatic acc_type shr_rnd(acc_type v, int unsigned s);
      logic [67:0] mag;
      mag = v[67] ? 68'(-v) : 68'(v);
      mag = (mag + (68'(1) << (s - 1))) >> s;
      return v[67] ? -acc_type'(mag) : acc_type'(mag);
   endfunction

   // clamp to the 32-bit signed range
   function automatic fix_type sat32(acc_type v);
      fix_type r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/lavm_norm.sv =====
// lavm_norm: pipelined unit-vector unit (shift normalize, square sum, root, three divides)
// depends on lavm_pkg; instantiated by look_at_view_matrix
module lavm_norm #(
   parameter int unsigned FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lavm_pkg::wide_type in_vec [3],
   output logic               out_valid,
   output lavm_pkg::fix_type  out_vec [3]
);
   import lavm_pkg::*;

   localparam int unsigned SH_N = 6;
   localparam int unsigned SQ_N = 16;
   localparam int unsigned DV_N = (FRAC_BITS + 2) / 2;
   localparam int unsigned LAT  = norm_lat(FRAC_BITS);
   localparam int unsigned FW   = 93;

   typedef struct packed {
      logic       zero;
      logic [2:0] neg;
   } flag_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
      logic [63:0] xs;
   } sqs_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [30:0] dl;
      logic [31:0] q;
   } dvs_type;

   // one root digit
   function automatic sqs_type sq_step(sqs_type st);
      sqs_type     nx;
      logic [35:0] rem2;
      logic [35:0] trial;
      rem2  = {st.rem[33:0], st.xs[63:62]};
      trial = {2'b00, st.root, 2'b01};
      nx.xs = {st.xs[61:0], 2'b00};
      if (rem2 >= trial) begin
         nx.rem  = rem2 - trial;
         nx.root = {st.root[30:0], 1'b1};
      end else begin
         nx.rem  = rem2;
         nx.root = {st.root[30:0], 1'b0};
      end
      return nx;
   endfunction

   // one quotient bit
   function automatic dvs_type dv_step(dvs_type st, logic [31:0] len);
      dvs_type     nx;
      logic [32:0] rem2;
      rem2  = {st.rem, st.dl[30]};
      nx.dl = {st.dl[29:0], 1'b0};
      if (rem2 >= {1'b0, len}) begin
         nx.rem = 32'(rem2 - {1'b0, len});
         nx.q   = {st.q[30:0], 1'b1};
      end else begin
         nx.rem = rem2[31:0];
         nx.q   = {st.q[30:0], 1'b0};
      end
      return nx;
   endfunction

   // valid bits alongside the data
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end
   assign out_valid = vld_ff[LAT-1];

   // magnitudes placed in a wide frame so every later shift is to the right
   logic [61:0]   mag_in [3];
   logic [FW-1:0] x_ff [SH_N+1][3];
   flag_type      flag_ff [LAT-1];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = in_vec[i][63] ? 62'(-in_vec[i]) : 62'(in_vec[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         x_ff[0][i]         <= {mag_in[i], 31'b0};
         flag_ff[0].neg[i]  <= in_vec[i][63];
      end
      flag_ff[0].zero <= ((mag_in[0] | mag_in[1] | mag_in[2]) == '0);
      for (int k = 1; k < LAT - 1; k++) begin
         flag_ff[k] <= flag_ff[k-1];
      end
   end

   // shift search: bring the largest magnitude's top bit to bit 30
   for (genvar s = 1; s <= SH_N; s++) begin : g_shift
      localparam int unsigned K = 1 << (SH_N - s);
      logic [FW-1:0] orv;
      assign orv = x_ff[s-1][0] | x_ff[s-1][1] | x_ff[s-1][2];
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            x_ff[s][i] <= (|orv[FW-1:30+K]) ? (x_ff[s-1][i] >> K) : x_ff[s-1][i];
         end
      end
   end

   // squares, then their sum
   logic [30:0] m7_ff [3];
   logic [61:0] sq7_ff [3];
   logic [30:0] m8_ff [3];
   logic [63:0] sum_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         m7_ff[i]  <= x_ff[SH_N][i][30:0];
         sq7_ff[i] <= 62'(x_ff[SH_N][i][30:0]) * 62'(x_ff[SH_N][i][30:0]);
      end
      m8_ff  <= m7_ff;
      sum_ff <= 64'(sq7_ff[0]) + 64'(sq7_ff[1]) + 64'(sq7_ff[2]);
   end

   // integer square root, two digits a stage
   sqs_type     sq_ff [SQ_N];
   logic [30:0] msq_ff [SQ_N][3];
   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      sqs_type     src;
      logic [30:0] msrc [3];
      if (j == 0) begin : g_first
         assign src  = {36'd0, 32'd0, sum_ff};
         assign msrc = m8_ff;
      end else begin : g_next
         assign src  = sq_ff[j-1];
         assign msrc = msq_ff[j-1];
      end
      always_ff @(posedge clock) begin
         sq_ff[j]  <= sq_step(sq_step(src));
         msq_ff[j] <= msrc;
      end
   end

   // dividend with half the length added for rounding
   logic [61:0] dvd [3];
   dvs_type     pv_ff [3];
   logic [31:0] plen_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvd[i] = (62'(msq_ff[SQ_N-1][i]) << FRAC_BITS) + 62'(sq_ff[SQ_N-1].root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pv_ff[i].rem <= 32'(dvd[i] >> (FRAC_BITS + 1));
         pv_ff[i].dl  <= 31'(dvd[i] << (30 - FRAC_BITS));
         pv_ff[i].q   <= '0;
      end
      plen_ff <= sq_ff[SQ_N-1].root;
   end

   // restoring divides, two quotient bits a stage (one in the last stage when FRAC_BITS is even)
   dvs_type     dv_ff [DV_N][3];
   logic [31:0] dlen_ff [DV_N];
   for (genvar j = 0; j < DV_N; j++) begin : g_div
      dvs_type     src [3];
      dvs_type     nxt [3];
      logic [31:0] lsrc;
      if (j == 0) begin : g_first
         assign src  = pv_ff;
         assign lsrc = plen_ff;
      end else begin : g_next
         assign src  = dv_ff[j-1];
         assign lsrc = dlen_ff[j-1];
      end
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            nxt[i] = src[i];
            for (int u = 0; u < 2; u++) begin
               if (2 * j + u <= FRAC_BITS) begin
                  nxt[i] = dv_step(nxt[i], lsrc);
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         dv_ff[j]   <= nxt;
         dlen_ff[j] <= lsrc;
      end
   end

   // sign back on; a zero vector stays zero
   fix_type out_ff [3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (flag_ff[LAT-2].zero) begin
            out_ff[i] <= '0;
         end else if (flag_ff[LAT-2].neg[i]) begin
            out_ff[i] <= -fix_type'(dv_ff[DV_N-1][i].q);
         end else begin
            out_ff[i] <= fix_type'(dv_ff[DV_N-1][i].q);
         end
      end
   end
   assign out_vec = out_ff;

endmodule

// ===== hdl/look_at_view_matrix.sv =====
// look_at_view_matrix: an accepted start passes the input stage, the forward and up
//   normalize units, the cross product, the side normalize unit, the second cross
//   product with rounding, the row sequencer and the row stages to row 0 on rsp_valid;
//   rows 1 to 3 follow with no gaps, one row per cycle from the shared row datapath,
//   so busy holds off the next word after each accept until the spacing count ends
// reset (synchronous, active high) clears all valid bits, the row sequencer and the
//   registers to up = (0, 0, 1.0) and zoom = 1.0; no result is pending after reset
// depends on lavm_pkg and lavm_norm
module look_at_view_matrix #(
   parameter int unsigned FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lavm_pkg::req_type req_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   output logic              rsp_valid,
   output lavm_pkg::rsp_type rsp_word
);
   import lavm_pkg::*;

   localparam int unsigned LAT   = norm_lat(FRAC_BITS);
   localparam int unsigned FWD_D = LAT + 2;
   localparam int unsigned EYE_D = 2 * LAT + 5;

   // configuration registers
   fix_type     up_ff [3];
   logic [30:0] zoom_ff;
   fix_type     zoom_s;
   assign csr_ready = 1'b1;
   assign zoom_s    = fix_type'({1'b0, zoom_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff[0] <= UP_X_RST;
         up_ff[1] <= UP_Y_RST;
         up_ff[2] <= UP_Z_RST;
         zoom_ff  <= ZOOM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_UP_X: up_ff[0] <= csr_data;
            CSR_UP_Y: up_ff[1] <= csr_data;
            CSR_UP_Z: up_ff[2] <= csr_data;
            CSR_ZOOM: zoom_ff  <= csr_data[30:0];
            default:  zoom_ff  <= zoom_ff;
         endcase
      end
   end

   // accept and spacing of words
   logic       acc;
   logic [1:0] gap_ff;
   logic [1:0] gap_in;
   assign acc  = start && !busy;
   assign busy = (gap_ff != 2'd0);
   always_comb begin
      gap_in = gap_ff;
      if (acc) begin
         gap_in = 2'd3;
      end else if (gap_ff != 2'd0) begin
         gap_in = gap_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   // input stage: eye and aim - eye
   logic                v0_ff;
   fix_type             eye0_ff [3];
   logic signed [32:0]  diff0_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      eye0_ff[0]  <= req_word.eye_x;
      eye0_ff[1]  <= req_word.eye_y;
      eye0_ff[2]  <= req_word.eye_z;
      diff0_ff[0] <= 33'(req_word.aim_x) - 33'(req_word.eye_x);
      diff0_ff[1] <= 33'(req_word.aim_y) - 33'(req_word.eye_y);
      diff0_ff[2] <= 33'(req_word.aim_z) - 33'(req_word.eye_z);
   end

   // forward and up unit vectors in parallel
   wide_type na_in [3];
   wide_type nb_in [3];
   fix_type  fwd [3];
   fix_type  upn [3];
   logic     na_valid;
   logic     nb_valid;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         na_in[i] = 64'(diff0_ff[i]);
         nb_in[i] = 64'(up_ff[i]);
      end
   end

   lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v0_ff),
      .in_vec   (na_in),
      .out_valid(na_valid),
      .out_vec  (fwd)
   );

   lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v0_ff),
      .in_vec   (nb_in),
      .out_valid(nb_valid),
      .out_vec  (upn)
   );

   // forward x up: products, then differences
   logic     c1_vld_ff;
   logic     c2_vld_ff;
   wide_type c1_ff [6];
   wide_type c2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
      end else begin
         c1_vld_ff <= na_valid;
         c2_vld_ff <= c1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff[0] <= 64'(fwd[1]) * 64'(upn[2]);
      c1_ff[1] <= 64'(fwd[2]) * 64'(upn[1]);
      c1_ff[2] <= 64'(fwd[2]) * 64'(upn[0]);
      c1_ff[3] <= 64'(fwd[0]) * 64'(upn[2]);
      c1_ff[4] <= 64'(fwd[0]) * 64'(upn[1]);
      c1_ff[5] <= 64'(fwd[1]) * 64'(upn[0]);
      c2_ff[0] <= c1_ff[0] - c1_ff[1];
      c2_ff[1] <= c1_ff[2] - c1_ff[3];
      c2_ff[2] <= c1_ff[4] - c1_ff[5];
   end

   // side unit vector
   fix_type side [3];
   logic    nc_valid;
   lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_side (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c2_vld_ff),
      .in_vec   (c2_ff),
      .out_valid(nc_valid),
      .out_vec  (side)
   );

   // forward and eye wait for the side vector
   fix_type fwd_dl_ff [FWD_D][3];
   fix_type eye_dl_ff [EYE_D][3];
   always_ff @(posedge clock) begin
      fwd_dl_ff[0] <= fwd;
      for (int k = 1; k < FWD_D; k++) begin
         fwd_dl_ff[k] <= fwd_dl_ff[k-1];
      end
      eye_dl_ff[0] <= eye0_ff;
      for (int k = 1; k < EYE_D; k++) begin
         eye_dl_ff[k] <= eye_dl_ff[k-1];
      end
   end

   // side x forward, then rounding to true up
   logic     c3_vld_ff;
   logic     c4_vld_ff;
   logic     c5_vld_ff;
   wide_type c3_ff [6];
   wide_type c4_ff [3];
   vec_type  tup5_ff [3];
   fix_type  side3_ff [3];
   fix_type  side4_ff [3];
   fix_type  side5_ff [3];
   fix_type  fwd3_ff [3];
   fix_type  fwd4_ff [3];
   fix_type  fwd5_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         c3_vld_ff <= 1'b0;
         c4_vld_ff <= 1'b0;
         c5_vld_ff <= 1'b0;
      end else begin
         c3_vld_ff <= nc_valid;
         c4_vld_ff <= c3_vld_ff;
         c5_vld_ff <= c4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c3_ff[0] <= 64'(side[1]) * 64'(fwd_dl_ff[FWD_D-1][2]);
      c3_ff[1] <= 64'(side[2]) * 64'(fwd_dl_ff[FWD_D-1][1]);
      c3_ff[2] <= 64'(side[2]) * 64'(fwd_dl_ff[FWD_D-1][0]);
      c3_ff[3] <= 64'(side[0]) * 64'(fwd_dl_ff[FWD_D-1][2]);
      c3_ff[4] <= 64'(side[0]) * 64'(fwd_dl_ff[FWD_D-1][1]);
      c3_ff[5] <= 64'(side[1]) * 64'(fwd_dl_ff[FWD_D-1][0]);
      side3_ff <= side;
      fwd3_ff  <= fwd_dl_ff[FWD_D-1];
      c4_ff[0] <= c3_ff[0] - c3_ff[1];
      c4_ff[1] <= c3_ff[2] - c3_ff[3];
      c4_ff[2] <= c3_ff[4] - c3_ff[5];
      side4_ff <= side3_ff;
      fwd4_ff  <= fwd3_ff;
      for (int i = 0; i < 3; i++) begin
         tup5_ff[i] <= 34'(shr_rnd(68'(c4_ff[i]), FRAC_BITS));
      end
      side5_ff <= side4_ff;
      fwd5_ff  <= fwd4_ff;
   end

   // row bank and sequencer: one row a cycle, in the order side, up, back, homogeneous
   vec_type    bank_ff [3][3];
   fix_type    beye_ff [3];
   rowsel_type cnt_ff;
   logic       act_ff;
   rowsel_type cnt_in;
   logic       act_in;
   always_comb begin
      cnt_in = cnt_ff;
      act_in = act_ff;
      if (c5_vld_ff) begin
         cnt_in = ROW_SIDE;
         act_in = 1'b1;
      end else if (act_ff) begin
         cnt_in = rowsel_type'(cnt_ff + 2'd1);
         act_in = (cnt_ff != ROW_HOMOG);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= ROW_SIDE;
         act_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c5_vld_ff) begin
         for (int i = 0; i < 3; i++) begin
            bank_ff[0][i] <= vec_type'(side5_ff[i]);
            bank_ff[1][i] <= tup5_ff[i];
            bank_ff[2][i] <= -vec_type'(fwd5_ff[i]);
         end
         beye_ff <= eye_dl_ff[EYE_D-1];
      end
   end

   // row stage: pick the row vector
   logic       r0_vld_ff;
   rowsel_type r0_row_ff;
   vec_type    r0_vec_ff [3];
   fix_type    r0_eye_ff [3];
   vec_type    r0_vec_in [3];
   always_comb begin
      case (cnt_ff)
         ROW_SIDE: r0_vec_in = bank_ff[0];
         ROW_UP:   r0_vec_in = bank_ff[1];
         ROW_BACK: r0_vec_in = bank_ff[2];
         default:  r0_vec_in = '{default: '0};
      endcase
   end

   // multiply stages: dot terms and zoomed entries
   logic       r1_vld_ff, r2_vld_ff, r3_vld_ff, r4_vld_ff, r5_vld_ff;
   rowsel_type r1_row_ff, r2_row_ff, r3_row_ff, r4_row_ff;
   logic signed [65:0] dp_ff [3];
   logic signed [65:0] zr_ff [3];
   acc_type    dot_ff;
   fix_type    col2_ff [3];
   fix_type    col3_ff [3];
   fix_type    col4_ff [3];
   fix_type    t_ff;
   wide_type   zt_ff;
   rsp_type    rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         r0_vld_ff <= 1'b0;
         r1_vld_ff <= 1'b0;
         r2_vld_ff <= 1'b0;
         r3_vld_ff <= 1'b0;
         r4_vld_ff <= 1'b0;
         r5_vld_ff <= 1'b0;
      end else begin
         r0_vld_ff <= act_ff;
         r1_vld_ff <= r0_vld_ff;
         r2_vld_ff <= r1_vld_ff;
         r3_vld_ff <= r2_vld_ff;
         r4_vld_ff <= r3_vld_ff;
         r5_vld_ff <= r4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_row_ff <= cnt_ff;
      r0_vec_ff <= r0_vec_in;
      r0_eye_ff <= beye_ff;
      // products
      for (int i = 0; i < 3; i++) begin
         dp_ff[i] <= 66'(r0_vec_ff[i]) * 66'(r0_eye_ff[i]);
         zr_ff[i] <= 66'(r0_vec_ff[i]) * 66'(zoom_s);
      end
      r1_row_ff <= r0_row_ff;
      // dot sum and rounded entries
      dot_ff <= 68'(dp_ff[0]) + 68'(dp_ff[1]) + 68'(dp_ff[2]);
      for (int i = 0; i < 3; i++) begin
         col2_ff[i] <= sat32(shr_rnd(68'(zr_ff[i]), FRAC_BITS));
      end
      r2_row_ff <= r1_row_ff;
      // translation
      t_ff      <= sat32(-shr_rnd(dot_ff, FRAC_BITS));
      col3_ff   <= col2_ff;
      r3_row_ff <= r2_row_ff;
      // zoomed translation
      zt_ff     <= 64'(t_ff) * 64'(zoom_s);
      col4_ff   <= col3_ff;
      r4_row_ff <= r3_row_ff;
      // output word; the last row is constant
      rsp_ff.row_index <= r4_row_ff;
      if (r4_row_ff == ROW_HOMOG) begin
         rsp_ff.col_zero  <= '0;
         rsp_ff.col_one   <= '0;
         rsp_ff.col_two   <= '0;
         rsp_ff.col_three <= fix_type'(32'd1 << FRAC_BITS);
         rsp_ff.last_row  <= 1'b1;
      end else begin
         rsp_ff.col_zero  <= col4_ff[0];
         rsp_ff.col_one   <= col4_ff[1];
         rsp_ff.col_two   <= col4_ff[2];
         rsp_ff.col_three <= sat32(shr_rnd(68'(zt_ff), FRAC_BITS));
         rsp_ff.last_row  <= 1'b0;
      end
   end

   assign rsp_valid = r5_vld_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   // an accepted word holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accept not followed by busy");

   // both unit-vector pipes stay in step
   a_norm_aligned: assert property (@(posedge clock) disable iff (reset)
      na_valid == nb_valid)
      else $error("forward and up pipes out of step");

   // a new row set only lands when the sequencer is free or on its last row
   a_bank_free: assert property (@(posedge clock) disable iff (reset)
      c5_vld_ff |-> (!act_ff || cnt_ff == ROW_HOMOG))
      else $error("row bank overwritten mid-matrix");

   // rows of one matrix come out back to back in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last_row) |=>
         (rsp_valid && rsp_word.row_index == 2'($past(rsp_word.row_index) + 2'd1)))
      else $error("row sequence broken");

   // last_row marks exactly the homogeneous row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.last_row == (rsp_word.row_index == ROW_HOMOG)))
      else $error("last_row flag mismatch");
`endif

endmodule

// ===== tb/sv/look_at_view_matrix_test.sv =====
// look_at_view_matrix_test: self-checking bench for the look-at view matrix block
// depends on lavm_pkg and look_at_view_matrix; a class predicts and checks each matrix row
`timescale 1ns / 100ps

module look_at_view_matrix_test;
   import lavm_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;

   // predicts the four rows of each camera word and checks the block's rows
   class view_matrix_board;
      longint up_ref [3];
      longint zoom_scale;
      rsp_type expected_rows [$];
      int error_count;
      int rows_seen;

      function new();
         up_ref[0] = 0;
         up_ref[1] = 0;
         up_ref[2] = longint'(1) << FRAC;
         zoom_scale = longint'(1) << FRAC;
         error_count = 0;
         rows_seen = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [31:0] val);
         case (idx)
            CSR_UP_X: up_ref[0] = longint'(signed'(val));
            CSR_UP_Y: up_ref[1] = longint'(signed'(val));
            CSR_UP_Z: up_ref[2] = longint'(signed'(val));
            CSR_ZOOM: zoom_scale = longint'({33'd0, val[30:0]});
            default: ;
         endcase
      endfunction

      // rounding right shift of the magnitude, ties away from zero
      function longint round_shift(longint v, int s);
         longint unsigned m;
         m = (v < 0) ? longint'(0) - v : v;
         m = (m + (longint'(1) << (s - 1))) >> s;
         return (v < 0) ? -longint'(m) : longint'(m);
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res, bitv;
         res = 0;
         bitv = longint'(1) << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // scale magnitudes into [2^30, 2^31) and divide by the length; zero stays zero
      function void unit(input longint c [3], output longint o [3]);
         longint unsigned m [3];
         longint unsigned top, len;
         for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? longint'(0) - c[i] : c[i];
         top = m[0];
         if (m[1] > top) top = m[1];
         if (m[2] > top) top = m[2];
         if (top == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
         end
         while (top >= (longint'(1) << 31)) begin
            top >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
         end
         while (top < (longint'(1) << 30)) begin
            top <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
         end
         len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
         for (int i = 0; i < 3; i++) begin
            top = ((m[i] << FRAC) + (len >> 1)) / len;
            o[i] = (c[i] < 0) ? -longint'(top) : longint'(top);
         end
      endfunction

      function void cross3(input longint a [3], input longint b [3], output longint r [3]);
         r[0] = a[1] * b[2] - a[2] * b[1];
         r[1] = a[2] * b[0] - a[0] * b[2];
         r[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function logic [31:0] zoomed(longint v);
         longint z;
         z = clamp32(round_shift(v * zoom_scale, FRAC));
         return z[31:0];
      endfunction

      function void push_row(rowsel_type idx, longint r [3], longint eye [3]);
         rsp_type row;
         longint dot, t;
         dot = r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2];
         t = clamp32(-round_shift(dot, FRAC));
         row.row_index = idx;
         row.col_zero = zoomed(r[0]);
         row.col_one = zoomed(r[1]);
         row.col_two = zoomed(r[2]);
         row.col_three = zoomed(t);
         row.last_row = 1'b0;
         expected_rows.push_back(row);
      endfunction

      // camera word accepted: queue its four rows
      function void note_camera(req_type w);
         longint eye [3], diff [3], fwd [3], u [3], sraw [3], side [3];
         longint traw [3], tup [3], back [3];
         rsp_type row;
         eye[0] = longint'(w.eye_x);
         eye[1] = longint'(w.eye_y);
         eye[2] = longint'(w.eye_z);
         diff[0] = longint'(w.aim_x) - eye[0];
         diff[1] = longint'(w.aim_y) - eye[1];
         diff[2] = longint'(w.aim_z) - eye[2];
         unit(diff, fwd);
         unit(up_ref, u);
         cross3(fwd, u, sraw);
         unit(sraw, side);
         cross3(side, fwd, traw);
         for (int i = 0; i < 3; i++) begin
            tup[i] = round_shift(traw[i], FRAC);
            back[i] = -fwd[i];
         end
         push_row(ROW_SIDE, side, eye);
         push_row(ROW_UP, tup, eye);
         push_row(ROW_BACK, back, eye);
         row.row_index = ROW_HOMOG;
         row.col_zero = 0;
         row.col_one = 0;
         row.col_two = 0;
         row.col_three = 32'd1 << FRAC;
         row.last_row = 1'b1;
         expected_rows.push_back(row);
      endfunction

      function void check_row(rsp_type got);
         rsp_type want;
         rows_seen++;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row, actual %h", $realtime, got);
            error_count++;
            return;
         end
         want = expected_rows.pop_front();
         if (got !== want) begin
            $display("%0t: row mismatch, expected idx %0d %h %h %h %h last %b",
                     $realtime, want.row_index, want.col_zero, want.col_one,
                     want.col_two, want.col_three, want.last_row);
            $display("%0t:               actual   idx %0d %h %h %h %h last %b",
                     $realtime, got.row_index, got.col_zero, got.col_one,
                     got.col_two, got.col_three, got.last_row);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_word;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;
   logic rsp_valid;
   rsp_type rsp_word;

   view_matrix_board board;
   int words_sent;
   int settings_used;

   look_at_view_matrix uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // row monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_row(rsp_word);
   end

   // send one camera word and hold it until accepted
   task automatic send_camera(req_type w);
      @(negedge clock);
      start = 1'b1;
      req_word = w;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_camera(w);
      words_sent++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic drain();
      idle_cycles(1);
      while (board.expected_rows.size() != 0) @(negedge clock);
      idle_cycles(4);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_view(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                           logic [31:0] zm);
      drain();
      write_reg(CSR_UP_X, ux);
      write_reg(CSR_UP_Y, uy);
      write_reg(CSR_UP_Z, uz);
      write_reg(CSR_ZOOM, zm);
      settings_used++;
   endtask

   function automatic req_type cam(int ex, int ey, int ez, int ax, int ay, int az);
      req_type w;
      w.eye_x = ex; w.eye_y = ey; w.eye_z = ez;
      w.aim_x = ax; w.aim_y = ay; w.aim_z = az;
      return w;
   endfunction

   // mostly modest coordinates, some full-range ones
   function automatic logic [31:0] rand_coord(int mode);
      logic [31:0] v;
      if (mode == 0) v = $urandom;
      else if (mode == 1) v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      else v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      return v;
   endfunction

   function automatic req_type rand_camera();
      req_type w;
      int mode;
      mode = $urandom_range(0, 2);
      w.eye_x = rand_coord(mode); w.eye_y = rand_coord(mode); w.eye_z = rand_coord(mode);
      w.aim_x = rand_coord(mode); w.aim_y = rand_coord(mode); w.aim_z = rand_coord(mode);
      case ($urandom_range(0, 11))
         0: w.aim_x = w.eye_x;
         1: begin
            w.aim_x = w.eye_x; w.aim_y = w.eye_y; w.aim_z = w.eye_z;
         end
         2: begin
            w.aim_x = w.eye_x; w.aim_y = w.eye_y;
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic random_run(int n, bit with_gaps);
      for (int i = 0; i < n; i++) begin
         send_camera(rand_camera());
         if (with_gaps && $urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
      end
   endtask

   initial begin
      board = new();
      words_sent = 0;
      settings_used = 1;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_UP_X;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default setup, degenerate and extreme cameras
      send_camera(cam(0, 0, 0, 65536, 0, 0));
      send_camera(cam(0, 0, 0, 0, 0, 0));
      send_camera(cam(100, 200, 300, 100, 200, 300));
      send_camera(cam(0, 0, 0, 0, 0, 65536));
      send_camera(cam(5, 5, 0, 5, 5, -123456));
      send_camera(cam(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h80000000, 32'h80000000));
      send_camera(cam(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      send_camera(cam(32'h80000000, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000));
      send_camera(cam(1, -1, 1, -1, 1, -1));
      send_camera(cam(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 1, 0));
      send_camera(cam(-1, -1, -1, 0, 0, 0));

      // max zoom and tilted up, translations saturate
      set_view(32'h00010000, 32'h00010000, 32'h80000000, 32'h7FFFFFFF);
      send_camera(cam(32'h7FFFFFFF, 32'h80000000, 12345, 0, 0, 0));
      send_camera(cam(0, 0, 0, 65536, 65536, -65536));
      send_camera(cam(3, 4, 5, 3, 4, 5));
      // zoom zero wipes rows 0 to 2
      set_view(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0);
      send_camera(cam(1000, 2000, 3000, -4000, 5000, 60000));
      send_camera(cam(32'h80000000, 32'h80000000, 0, 0, 0, 0));
      // zero up vector leaves side zero
      set_view(0, 0, 0, 32'h00020000);
      send_camera(cam(0, 0, 0, 65536, 65536, 65536));
      send_camera(cam(7, 8, 9, -70000, 8, 90000));
      // up along x, forward first parallel to it, then along y
      set_view(32'h7FFFFFFF, 0, 0, 32'h00010000);
      send_camera(cam(0, 0, 0, 32'h00400000, 0, 0));
      send_camera(cam(0, 0, 0, 0, 32'h00400000, 0));

      // random setups, each written while idle
      for (int p = 0; p < 4; p++) begin
         set_view($urandom, $urandom, $urandom, 32'($urandom_range(0, 32'h0003_FFFF)));
         random_run(15, 1'b1);
      end
      // hold off until every row has come, then a gapped run, the default view and a burst
      drain();
      random_run(10, 1'b1);
      set_view(0, 0, 32'h00010000, 32'h00010000);
      random_run(30, 1'b0);
      idle_cycles(1);

      while (board.expected_rows.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d camera words and %0d rows over %0d register setups",
               words_sent, board.rows_seen, settings_used);
      $display("setups included zero and max zoom, zero and extreme up vectors");
      if (board.error_count == 0 && board.expected_rows.size() == 0) begin
         $display("look_at_view_matrix_test: done, clean");
      end else begin
         $display("look_at_view_matrix_test: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("timeout waiting for matrix rows");
      $display("look_at_view_matrix_test: done, errors");
      $finish;
   end

endmodule
